// File: src/roulette_wheel_select_unit_macros.svh
// Assertion macros for the roulette wheel selection unit.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ROULETTE_WHEEL_SELECT_UNIT_MACROS_SVH
`define ROULETTE_WHEEL_SELECT_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RWS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("roulette wheel select check failed");

// The consequent must hold in the cycle after the antecedent.
`define RWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("roulette wheel select check failed");

`endif

// File: src/rws_pkg.sv
// Package for the roulette wheel selection unit: field widths, defaults and codes.
// No dependencies; used by the channel interfaces and the top level.
package rws_pkg;

  localparam int POP_MAX_DEF      = 256;
  localparam int FITNESS_BITS_DEF = 32;
  localparam int IDX_LIMIT        = 256;

  localparam int MEMBER_W    = 8;
  localparam int FIT_IN_W    = 32;
  localparam int FRAC_BITS   = 32;
  localparam int POP_COUNT_W = 9;

  localparam logic [POP_COUNT_W-1:0] POP_COUNT_RST = POP_COUNT_W'(256);

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SELECT = 1'b1
  } op_t;

endpackage

// File: src/rws_if.sv
// Valid/ready channel interfaces for the roulette wheel selection unit.
// Depends on rws_pkg for the field widths.
interface rws_in_if import rws_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   operation;
  logic [MEMBER_W-1:0]    member_index;
  logic [FIT_IN_W-1:0]    fitness_value;
  logic [FRAC_BITS-1:0]   random_fraction;

  modport source (output valid, operation, member_index, fitness_value, random_fraction,
                  input ready);
  modport sink (input valid, operation, member_index, fitness_value, random_fraction,
                output ready);
endinterface

interface rws_out_if import rws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MEMBER_W-1:0] selected_index;
  logic                overrun;

  modport source (output valid, selected_index, overrun, input ready);
  modport sink (input valid, selected_index, overrun, output ready);
endinterface

interface rws_cfg_if import rws_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [POP_COUNT_W-1:0] pop_count;

  modport source (output valid, pop_count, input ready);
  modport sink (input valid, pop_count, output ready);
endinterface

// File: src/rws_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module rws_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/roulette_wheel_select_unit.sv
// Roulette wheel selection unit: fitness table in RAM, one shared adder under a sequencer.
// A select beat sums the n members one per RAM read, runs 32 shift-add steps for the dart
// and k+1 walk steps to member k, then may wait on out_bus.ready; one item at a time.
// Reset is synchronous, active low; a clearing pass zeroes all min(POP_MAX, 256) table
// entries after reset, during which no input beat is taken.
module roulette_wheel_select_unit import rws_pkg::*; #(
  parameter int POP_MAX      = POP_MAX_DEF,
  parameter int FITNESS_BITS = FITNESS_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  rws_in_if.sink   in_bus,
  rws_out_if.source out_bus,
  rws_cfg_if.sink  cfg_bus
);

`include "roulette_wheel_select_unit_macros.svh"

  localparam int DEPTH = (POP_MAX < IDX_LIMIT) ? POP_MAX : IDX_LIMIT;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int SUM_W = FITNESS_BITS + IDX_W;
  localparam int CNT_W = $clog2(FRAC_BITS);
  localparam logic [POP_COUNT_W-1:0] LAST_MAX = POP_COUNT_W'(DEPTH - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_WALK,
    ST_HOLD
  } state_t;

  state_t                 state_r;
  logic [IDX_W-1:0]       idx_r;
  logic [POP_COUNT_W-1:0] pop_r;
  logic [SUM_W-1:0]       total_r;
  logic [SUM_W-1:0]       dart_r;
  logic [SUM_W-1:0]       run_r;
  logic [FRAC_BITS-1:0]   frac_r;
  logic [CNT_W-1:0]       bit_cnt_r;
  logic                   flag_r;
  logic                   out_valid_r;
  logic [MEMBER_W-1:0]    out_idx_r;
  logic                   out_flag_r;

  logic [POP_COUNT_W-1:0]  last9;
  logic [IDX_W-1:0]        last_idx;
  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  logic [FITNESS_BITS-1:0] ram_wdata;
  logic [IDX_W-1:0]        ram_raddr;
  logic [FITNESS_BITS-1:0] ram_rdata;
  logic [SUM_W-1:0]        rdata_ext;
  logic [SUM_W-1:0]        add_a;
  logic [SUM_W-1:0]        add_b;
  logic [SUM_W:0]          add_sum;
  logic                    in_fire;

  always_comb begin
    if (pop_r == '0) begin
      last9 = '0;
    end else if (pop_r > POP_COUNT_W'(DEPTH)) begin
      last9 = LAST_MAX;
    end else begin
      last9 = pop_r - POP_COUNT_W'(1);
    end
  end

  assign last_idx = last9[IDX_W-1:0];
  assign in_fire  = in_bus.valid && (state_r == ST_IDLE);

  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r;
      ram_wdata = '0;
    end else begin
      ram_we    = in_fire && (in_bus.operation == OP_WRITE) &&
                  (POP_COUNT_W'(in_bus.member_index) <= last9);
      ram_waddr = IDX_W'(in_bus.member_index);
      ram_wdata = FITNESS_BITS'(in_bus.fitness_value);
    end
  end

  always_comb begin
    case (state_r)
      ST_SUM, ST_WALK: ram_raddr = idx_r + IDX_W'(1);
      default:         ram_raddr = '0;
    endcase
  end

  rws_ram #(
    .WIDTH(FITNESS_BITS),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rdata_ext = SUM_W'(ram_rdata);

  always_comb begin
    case (state_r)
      ST_SUM: begin
        add_a = total_r;
        add_b = rdata_ext;
      end
      ST_MUL: begin
        add_a = dart_r;
        add_b = frac_r[0] ? total_r : '0;
      end
      ST_WALK: begin
        add_a = run_r;
        add_b = rdata_ext;
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = {1'b0, add_a} + {1'b0, add_b};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      idx_r       <= '0;
      pop_r       <= POP_COUNT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_bus.valid) begin
        pop_r <= cfg_bus.pop_count;
      end
      if (out_bus.ready && (state_r != ST_HOLD)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_CLEAR: begin
          if (idx_r == IDX_W'(DEPTH - 1)) begin
            idx_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_fire && (in_bus.operation == OP_SELECT)) begin
            idx_r   <= '0;
            total_r <= '0;
            frac_r  <= in_bus.random_fraction;
            state_r <= ST_SUM;
          end
        end
        ST_SUM: begin
          total_r <= add_sum[SUM_W-1:0];
          if (idx_r == last_idx) begin
            bit_cnt_r <= '0;
            dart_r    <= '0;
            state_r   <= ST_MUL;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_MUL: begin
          dart_r <= add_sum[SUM_W:1];
          frac_r <= frac_r >> 1;
          if (bit_cnt_r == CNT_W'(FRAC_BITS - 1)) begin
            idx_r   <= '0;
            run_r   <= '0;
            state_r <= ST_WALK;
          end else begin
            bit_cnt_r <= bit_cnt_r + CNT_W'(1);
          end
        end
        ST_WALK: begin
          run_r <= add_sum[SUM_W-1:0];
          if (add_sum[SUM_W-1:0] >= dart_r) begin
            flag_r  <= 1'b0;
            state_r <= ST_HOLD;
          end else if (idx_r == last_idx) begin
            flag_r  <= 1'b1;
            state_r <= ST_HOLD;
          end else begin
            idx_r <= idx_r + IDX_W'(1);
          end
        end
        ST_HOLD: begin
          if (!out_valid_r || out_bus.ready) begin
            out_valid_r <= 1'b1;
            out_idx_r   <= MEMBER_W'(idx_r);
            out_flag_r  <= flag_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_bus.ready          = (state_r == ST_IDLE);
  assign cfg_bus.ready         = 1'b1;
  assign out_bus.valid         = out_valid_r;
  assign out_bus.selected_index = out_idx_r;
  assign out_bus.overrun       = out_flag_r;

  `RWS_ASSERT_NOW(a_overrun_at_last, out_bus.valid && out_bus.overrun, out_bus.selected_index == MEMBER_W'(last_idx))
  `RWS_ASSERT_NOW(a_index_in_range, out_bus.valid, POP_COUNT_W'(out_bus.selected_index) <= last9)
  `RWS_ASSERT_NOW(a_dart_below_total, state_r == ST_WALK, (dart_r < total_r) || (total_r == '0))
  `RWS_ASSERT_NOW(a_walk_below_dart, (state_r == ST_WALK) && (idx_r != '0), run_r < dart_r)
  `RWS_ASSERT_NEXT(a_select_starts_sum, in_bus.valid && in_bus.ready && (in_bus.operation == OP_SELECT), state_r == ST_SUM)

endmodule
